>>> design/mbrm_pkg.sv
// Package for the Modbus TCP read master: codes, field types and the
// command record passed from the front end to the request serializer.
`default_nettype none
package mbrm_pkg;
   localparam logic [1:0] MODE_RX   = 2'd0;
   localparam logic [1:0] MODE_TICK = 2'd1;
   localparam logic [1:0] MODE_SEND = 2'd2;
   localparam logic [1:0] MODE_READ = 2'd3;

   localparam logic [1:0] KIND_TX      = 2'd0;
   localparam logic [1:0] KIND_STATUS  = 2'd1;
   localparam logic [1:0] KIND_READ    = 2'd2;
   localparam logic [1:0] KIND_TIMEOUT = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_SHORT     = 3'd1;
   localparam logic [2:0] ST_EXCEPTION = 3'd2;
   localparam logic [2:0] ST_UNEXPECT  = 3'd3;
   localparam logic [2:0] ST_BADCOUNT  = 3'd4;

   localparam logic [2:0] CSR_UNIT    = 3'd0;
   localparam logic [2:0] CSR_FIRST   = 3'd1;
   localparam logic [2:0] CSR_QTY     = 3'd2;
   localparam logic [2:0] CSR_TIMEOUT = 3'd3;
   localparam logic [2:0] CSR_GAP     = 3'd4;

   localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
   localparam logic [8:0] FRAME_MAX = 9'd511;
   localparam logic [8:0] HDR_LEN   = 9'd9;
   localparam int         REQ_BYTES = 12;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] detail;
   } frame_status_type;

   // One result slot from the front end; a send item carries its request fields.
   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  status;
      logic [7:0]  detail_code;
      logic [15:0] reg_value;
      logic        in_range;
      logic [6:0]  stored_count;
      logic [15:0] trans_id;
      logic [7:0]  unit_addr;
      logic [15:0] first_register;
      logic [15:0] register_quantity;
   } cmd_type;
endpackage
`default_nettype wire

>>> design/mbrm_if.sv
// Valid/ready channel interfaces for the request and result sides.
// Depends on nothing.
`default_nettype none
interface mbrm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] rx_byte;
   logic [6:0] read_index;
   modport source (output valid, mode, rx_byte, read_index, input ready);
   modport sink   (input valid, mode, rx_byte, read_index, output ready);
endinterface

interface mbrm_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  tx_byte;
   logic        last;
   logic [2:0]  status;
   logic [7:0]  detail_code;
   logic [15:0] reg_value;
   logic        in_range;
   logic [6:0]  stored_count;
   modport source (output valid, kind, tx_byte, last, status, detail_code, reg_value,
                   in_range, stored_count, input ready);
   modport sink   (input valid, kind, tx_byte, last, status, detail_code, reg_value,
                   in_range, stored_count, output ready);
endinterface
`default_nettype wire

>>> design/mbrm_queue.sv
// Short command queue between the front end and the back end.
// Depends on mbrm_pkg.
`default_nettype none
module mbrm_queue #(
   parameter int DEPTH_LOG2 = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire mbrm_pkg::cmd_type push_data,
   output logic                  room3,
   input  wire logic             pop,
   output logic                  not_empty,
   output mbrm_pkg::cmd_type     head
);
   import mbrm_pkg::*;
   localparam int DEPTH = 1 << DEPTH_LOG2;
   cmd_type mem_ff [DEPTH];
   logic [DEPTH_LOG2-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [DEPTH_LOG2:0]   cnt_ff, cnt_in;

   always_comb begin
      wr_in  = wr_ff + DEPTH_LOG2'(push);
      rd_in  = rd_ff + DEPTH_LOG2'(pop);
      cnt_in = cnt_ff + (DEPTH_LOG2+1)'(push) - (DEPTH_LOG2+1)'(pop);
   end
   assign not_empty = cnt_ff != '0;
   assign head      = mem_ff[rd_ff];
   // At least three free entries remain.
   assign room3     = cnt_ff <= (DEPTH_LOG2+1)'(DEPTH - 3);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= push_data;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> cnt_ff != (DEPTH_LOG2+1)'(DEPTH)) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty) else $error("queue underflow");
   a_count: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (DEPTH_LOG2+1)'(DEPTH)) else $error("queue count out of range");
endmodule
`default_nettype wire

>>> design/mbrm_front.sv
// Front end: frame assembly, frame check, timeout and register bank.
// Depends on mbrm_pkg.
`default_nettype none
module mbrm_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [1:0]        mode,
   input  wire logic [7:0]        rx_byte,
   input  wire logic [6:0]        read_index,
   input  wire logic [7:0]        unit_addr,
   input  wire logic [15:0]       first_register,
   input  wire logic [15:0]       register_quantity,
   input  wire logic [15:0]       reply_timeout,
   input  wire logic [7:0]        gap_limit,
   output logic                   push,
   output mbrm_pkg::cmd_type      push_data,
   output logic                   push2,
   output mbrm_pkg::cmd_type      push2_data
);
   import mbrm_pkg::*;
   logic [15:0] tid_ff, tid_in;
   logic [8:0]  len_ff, len_in;
   logic        open_ff, open_in;
   logic [7:0]  gap_ff, gap_in, func_ff, func_in, count_ff, count_in, high_ff, high_in;
   logic        bank_ff, bank_in, await_ff, await_in;
   logic [6:0]  live_ff, live_in;
   logic [15:0] wait_ff, wait_in;
   logic [15:0] bank_mem [256];
   logic        mem_we;
   logic [7:0]  mem_waddr;
   logic [15:0] mem_wdata;
   // Read pipeline: one stage holding the registered RAM data.
   logic        rd_v_ff;
   logic        rd_inr_ff;
   logic [6:0]  rd_cnt_ff;
   logic [15:0] rd_data_ff;
   frame_status_type fst;
   logic        close, tmo;
   logic [8:0]  d;
   logic [15:0] wait_inc;
   cmd_type     c_a, c_b;

   always_comb begin
      fst = '{status: ST_OK, detail: 8'd0};
      if (len_ff < HDR_LEN) fst.status = ST_SHORT;
      else if (func_ff != FUNC_READ_HOLDING) begin
         if (func_ff[7]) fst = '{status: ST_EXCEPTION, detail: count_ff};
         else            fst = '{status: ST_UNEXPECT, detail: func_ff};
      end else if (count_ff[0] || len_ff < HDR_LEN + {1'b0, count_ff})
         fst.status = ST_BADCOUNT;
   end

   always_comb begin
      tid_in = tid_ff; len_in = len_ff; open_in = open_ff; gap_in = gap_ff;
      func_in = func_ff; count_in = count_ff; high_in = high_ff; bank_in = bank_ff;
      await_in = await_ff; live_in = live_ff; wait_in = wait_ff;
      mem_we = 1'b0; mem_waddr = '0; mem_wdata = {high_ff, rx_byte};
      close = 1'b0; tmo = 1'b0; d = len_ff - HDR_LEN;
      wait_inc = wait_ff + 16'(wait_ff != 16'hFFFF);
      if (accept) begin
         case (mode)
            MODE_RX: begin
               gap_in = '0;
               open_in = 1'b1;
               if (!open_ff) begin
                  len_in = 9'd1;
               end else begin
                  if (len_ff == 9'd7) func_in = rx_byte;
                  else if (len_ff == 9'd8) count_in = rx_byte;
                  else if (len_ff >= HDR_LEN) begin
                     if (!d[0]) high_in = rx_byte;
                     else if ({1'b0, d[8:1]} < {2'b0, count_ff[7:1]} && d[8:1] < 8'd128) begin
                        mem_we = 1'b1;
                        mem_waddr = {~bank_ff, d[7:1]};
                     end
                  end
                  if (len_ff != FRAME_MAX) len_in = len_ff + 9'd1;
               end
            end
            MODE_TICK: begin
               if (open_ff) begin
                  if (gap_ff >= gap_limit) begin
                     close = 1'b1;
                     open_in = 1'b0; len_in = '0; gap_in = '0;
                     if (fst.status == ST_OK) begin
                        bank_in = ~bank_ff;
                        live_in = count_ff[7:1];
                     end
                  end else gap_in = gap_ff + 8'd1;
               end
               if (await_ff && !(close && fst.status == ST_OK)) begin
                  wait_in = wait_inc;
                  if (wait_inc >= reply_timeout) begin
                     tmo = 1'b1;
                  end
               end
               if (close && fst.status == ST_OK) await_in = 1'b0;
               if (tmo) await_in = 1'b0;
            end
            MODE_SEND: begin
               tid_in = tid_ff + 16'd1; await_in = 1'b1; wait_in = '0;
            end
            default: ;
         endcase
      end
   end

   // Bank write and the registered read for the current read item.
   always_ff @(posedge clock) begin
      if (mem_we) bank_mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= bank_mem[{bank_ff, read_index}];
      rd_inr_ff  <= read_index < live_ff;
      rd_cnt_ff  <= live_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tid_ff <= 16'd1; len_ff <= '0; open_ff <= 1'b0; gap_ff <= '0;
         func_ff <= '0; count_ff <= '0; high_ff <= '0; bank_ff <= 1'b0;
         await_ff <= 1'b0; live_ff <= '0; wait_ff <= '0; rd_v_ff <= 1'b0;
      end else begin
         tid_ff <= tid_in; len_ff <= len_in; open_ff <= open_in; gap_ff <= gap_in;
         func_ff <= func_in; count_ff <= count_in; high_ff <= high_in; bank_ff <= bank_in;
         await_ff <= await_in; live_ff <= live_in; wait_ff <= wait_in;
         rd_v_ff <= accept && mode == MODE_READ;
      end
   end

   // Registered command slots: close and timeout may both come from one tick.
   always_comb begin
      c_a = '0; c_b = '0;
      c_a.trans_id = tid_ff; c_a.unit_addr = unit_addr;
      c_a.first_register = first_register; c_a.register_quantity = register_quantity;
      if (close) begin
         c_a.kind = KIND_STATUS; c_a.status = fst.status; c_a.detail_code = fst.detail;
      end else if (tmo) c_a.kind = KIND_TIMEOUT;
      else c_a.kind = KIND_TX;
      c_b.kind = KIND_TIMEOUT;
   end

   logic    p1_ff, p2_ff;
   cmd_type c1_ff, c2_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff <= 1'b0; p2_ff <= 1'b0;
      end else begin
         p1_ff <= accept && (close || tmo || mode == MODE_SEND);
         p2_ff <= close && tmo;
      end
      c1_ff <= c_a; c2_ff <= c_b;
   end

   // A read result comes in the cycle after its item, so it never meets a tick result.
   always_comb begin
      push = p1_ff || rd_v_ff;
      push_data = c1_ff;
      if (rd_v_ff) begin
         push_data = '0;
         push_data.kind = KIND_READ;
         push_data.in_range = rd_inr_ff;
         push_data.stored_count = rd_cnt_ff;
         push_data.reg_value = rd_inr_ff ? rd_data_ff : 16'd0;
      end
      push2 = p2_ff;
      push2_data = c2_ff;
   end

   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(p1_ff && rd_v_ff)) else $error("read and tick result collide");
   a_pair: assert property (@(posedge clock) disable iff (reset)
      p2_ff |-> p1_ff) else $error("second slot without first");
   a_send_waits: assert property (@(posedge clock) disable iff (reset)
      accept && mode == MODE_SEND |=> await_ff) else $error("send did not arm wait");
endmodule
`default_nettype wire

>>> design/mbrm_back.sv
// Back end: expands queued commands into result transactions.
// Depends on mbrm_pkg.
`default_nettype none
module mbrm_back (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          not_empty,
   input  wire mbrm_pkg::cmd_type head,
   output logic               pop,
   mbrm_rsp_if.source         rsp
);
   import mbrm_pkg::*;
   logic [3:0] idx_ff, idx_in;
   logic       multi;
   logic [7:0] txb;

   assign multi = head.kind == KIND_TX;
   always_comb begin
      case (idx_ff)
         4'd0:  txb = head.trans_id[15:8];
         4'd1:  txb = head.trans_id[7:0];
         4'd5:  txb = 8'd6;
         4'd6:  txb = head.unit_addr;
         4'd7:  txb = FUNC_READ_HOLDING;
         4'd8:  txb = head.first_register[15:8];
         4'd9:  txb = head.first_register[7:0];
         4'd10: txb = head.register_quantity[15:8];
         4'd11: txb = head.register_quantity[7:0];
         default: txb = 8'd0;
      endcase
   end

   always_comb begin
      rsp.valid = not_empty;
      rsp.kind = head.kind;
      rsp.tx_byte = multi ? txb : 8'd0;
      rsp.last = multi && idx_ff == 4'(REQ_BYTES - 1);
      rsp.status = head.status;
      rsp.detail_code = head.detail_code;
      rsp.reg_value = head.reg_value;
      rsp.in_range = head.in_range;
      rsp.stored_count = head.stored_count;
      pop = 1'b0; idx_in = idx_ff;
      if (not_empty && rsp.ready) begin
         if (!multi || idx_ff == 4'(REQ_BYTES - 1)) begin
            pop = 1'b1; idx_in = '0;
         end else idx_in = idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) idx_ff <= '0;
      else idx_ff <= idx_in;
   end

   a_idx: assert property (@(posedge clock) disable iff (reset)
      idx_ff < 4'(REQ_BYTES)) else $error("byte index out of range");
   a_idx_only_tx: assert property (@(posedge clock) disable iff (reset)
      idx_ff != '0 |-> not_empty && multi) else $error("index left over");
   a_pop_last: assert property (@(posedge clock) disable iff (reset)
      pop && multi |-> rsp.last) else $error("request popped early");
endmodule
`default_nettype wire

>>> design/modbus_tcp_read_master_top.sv
// Top level of the Modbus TCP read-holding-registers client.
// Depends on mbrm_pkg, mbrm_if, mbrm_front, mbrm_queue and mbrm_back.
//
// Usage: the req channel takes one transaction per item: a received byte, a
// time tick, a send command or a read of a stored register. Bytes, ticks and
// reads are taken one per cycle while req.ready is high. The rsp channel gives
// result transactions: twelve request bytes for a send (last marks the
// twelfth), a frame status when a tick closes a frame, a timeout, or read data.
// Timing: an accepted item pushes its result into the queue in the next
// cycle, so with an empty queue the result reaches rsp once the queue has
// registered it. A tick that both closes a frame and times out pushes its
// second result in the cycle after the first. A send gives twelve rsp
// transactions, so sustained sends are paced by the single byte serializer.
// The csr port writes unit_addr (0), first_register (1),
// register_quantity (2), reply_timeout_ticks (3) and gap_limit_ticks (4).
// Reset clears all control state and restores the register defaults; the
// stored register bank has no reset, but reads never reach unwritten entries.
// When rsp stalls, the eight-entry queue fills and req.ready drops once more
// than five entries are held, which leaves room for one result in flight and
// the two that the next item may bring. req.ready also drops while the
// second result of a tick that yields two results is pending.
`default_nettype none
module modbus_tcp_read_master_top #(
   parameter int QUEUE_DEPTH_LOG2 = 3
) (
   input  wire logic        clock,
   input  wire logic        reset,
   mbrm_req_if.sink         req,
   mbrm_rsp_if.source       rsp,
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_write_data
);
   import mbrm_pkg::*;
   logic [7:0]  unit_ff, gap_ff;
   logic [15:0] first_ff, qty_ff, tmo_ff;
   logic        accept, room, push, push2, pop, not_empty;
   cmd_type     pd, pd2, head;
   logic        extra_ff;
   cmd_type     extra_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff <= 8'd1; first_ff <= 16'd0; qty_ff <= 16'd5;
         tmo_ff <= 16'd3000; gap_ff <= 8'd10;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_UNIT:    unit_ff  <= csr_write_data[7:0];
            CSR_FIRST:   first_ff <= csr_write_data;
            CSR_QTY:     qty_ff   <= csr_write_data;
            CSR_TIMEOUT: tmo_ff   <= csr_write_data;
            CSR_GAP:     gap_ff   <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   // Items in flight may each bring up to two results; keep room for them.
   assign req.ready = room && !extra_ff;
   assign accept = req.valid && req.ready;

   mbrm_front u_front (
      .clock, .reset, .accept, .mode(req.mode), .rx_byte(req.rx_byte),
      .read_index(req.read_index), .unit_addr(unit_ff), .first_register(first_ff),
      .register_quantity(qty_ff), .reply_timeout(tmo_ff), .gap_limit(gap_ff),
      .push, .push_data(pd), .push2, .push2_data(pd2)
   );

   // The second result of a tick enters the queue in the cycle after the first.
   always_ff @(posedge clock) begin
      if (reset) extra_ff <= 1'b0;
      else extra_ff <= push2;
      extra_data_ff <= pd2;
   end

   logic    q_push;
   cmd_type q_data;
   assign q_push = push || extra_ff;
   assign q_data = extra_ff ? extra_data_ff : pd;

   // room leaves space for a result still in flight plus the two that the next
   // item may bring. While a second tick result is pending, a new item would
   // push in the same cycle as that result, so it waits.
   logic room3_raw;
   mbrm_queue #(.DEPTH_LOG2(QUEUE_DEPTH_LOG2)) u_queue (
      .clock, .reset, .push(q_push), .push_data(q_data), .room3(room3_raw),
      .pop, .not_empty, .head
   );
   assign room = room3_raw && !push2;

   mbrm_back u_back (.clock, .reset, .not_empty, .head, .pop, .rsp);

   a_no_collide: assert property (@(posedge clock) disable iff (reset)
      !(extra_ff && push)) else $error("extra slot collides with new result");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      extra_ff |-> !accept) else $error("accepted during extra slot");
   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      rsp.valid == not_empty) else $error("rsp valid mismatch");
endmodule
`default_nettype wire
